// ----- rtl/core/ldq_pkg.sv -----
// Package with the shared constants, codes and types of the linear deque engine.
`default_nettype none

package ldq_pkg;

    localparam int DEPTH = 128;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W = 8;
    localparam int CMP_W = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
    localparam int WORD_W = 32;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;
    localparam int IN_TDATA_W = ((MODE_W + WORD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((WORD_W + STAT_W + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] STAT_REFUSED   = 2'd3;

    typedef struct packed {
        logic accept;
        logic load_out;
    } ldq_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/linear_deque_engine.sv -----
// Top level of the linear deque engine: controller, datapath and stream ports.
//
// A double-ended queue held in a linear array of entries. Each input
// transaction on the s_ channel carries one operation (push front, push rear,
// pop front, pop rear) and produces exactly one result transaction on the
// m_ channel with the popped word and a status code.
// Each transaction first updates the indices and issues the entry RAM access,
// then moves the registered RAM read into the result register. The controller
// waits out the registered read before it takes the next transaction, so it
// takes no new transaction before the last one is through, and a result is
// presented once the execute state has loaded the result register.
// A new input transaction is taken while the previous result is being taken
// in the same cycle; while the receiver stalls, the result is held and
// s_tready stays low.
// The cfg channel writes the capacity register and is always ready; write it
// only while the block is idle.
// Reset empties the deque and sets the capacity to 128; stored words are left
// undefined and are never read before being written.
`default_nettype none

module linear_deque_engine (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // Fields from bit 0: mode[1:0], value[33:2], zero padding.
    input  wire logic [ldq_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // Fields from bit 0: value_out[31:0], status[33:32], zero padding.
    output logic      [ldq_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ldq_pkg::CAP_W-1:0]           cfg_data
);

    ldq_pkg::ldq_cmd_t           cmd;
    logic [ldq_pkg::WORD_W-1:0]  value_out;
    logic [ldq_pkg::STAT_W-1:0]  status;

    assign cfg_ready = 1'b1;

    ldq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ldq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .mode      (s_tdata[ldq_pkg::MODE_W-1:0]),
        .value     (s_tdata[ldq_pkg::MODE_W +: ldq_pkg::WORD_W]),
        .cfg_wr    (cfg_valid),
        .cfg_data  (cfg_data),
        .value_out (value_out),
        .status    (status)
    );

    assign m_tdata = ldq_pkg::OUT_TDATA_W'({status, value_out});

endmodule

`default_nettype wire

// ----- rtl/core/ldq_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module ldq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                   aclk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ldq_ctrl.sv -----
// Controller state machine that sequences each transaction through the datapath.
`default_nettype none

module ldq_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output ldq_pkg::ldq_cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } ldq_state_t;

    ldq_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd.accept   = 1'b0;
        cmd.load_out = 1'b0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.load_out = 1'b1;
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not enter execution");
    a_exec_to_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |=> m_valid_reg)
        else $error("result not presented after execution");
    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> !s_tready)
        else $error("input ready while a transaction executes");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/ldq_datapath.sv -----
// Datapath with the deque indices, the entry RAM, the capacity register and result registers.
`default_nettype none

module ldq_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire ldq_pkg::ldq_cmd_t               cmd,
    input  wire logic [ldq_pkg::MODE_W-1:0]      mode,
    input  wire logic [ldq_pkg::WORD_W-1:0]      value,
    input  wire logic                            cfg_wr,
    input  wire logic [ldq_pkg::CAP_W-1:0]       cfg_data,
    output logic      [ldq_pkg::WORD_W-1:0]      value_out,
    output logic      [ldq_pkg::STAT_W-1:0]      status
);

    localparam logic [ldq_pkg::IDX_W-1:0] IDX_ONE  = ldq_pkg::IDX_W'(1);
    localparam logic [ldq_pkg::IDX_W-1:0] IDX_ZERO = '0;
    localparam logic [ldq_pkg::CMP_W-1:0] DEPTH_C  = ldq_pkg::CMP_W'(ldq_pkg::DEPTH);

    logic [ldq_pkg::IDX_W-1:0]  front_reg, front_next;
    logic [ldq_pkg::IDX_W-1:0]  rear_reg, rear_next;
    logic                       empty_reg, empty_next;
    logic [ldq_pkg::CAP_W-1:0]  cap_reg;
    logic [ldq_pkg::STAT_W-1:0] pend_status_reg, pend_status_next;
    logic                       pend_read_reg, pend_read_next;
    logic [ldq_pkg::WORD_W-1:0] value_out_reg;
    logic [ldq_pkg::STAT_W-1:0] status_reg;

    logic [ldq_pkg::CMP_W-1:0]  cap_ext;
    logic [ldq_pkg::CMP_W-1:0]  used;
    logic                       rear_full;

    logic                       wr_en;
    logic [ldq_pkg::IDX_W-1:0]  wr_addr;
    logic                       rd_en;
    logic [ldq_pkg::IDX_W-1:0]  rd_addr;
    logic [ldq_pkg::WORD_W-1:0] rd_data;

    assign cap_ext   = ldq_pkg::CMP_W'(cap_reg);
    assign used      = (cap_ext == '0) ? ldq_pkg::CMP_W'(1) :
                       ((cap_ext > DEPTH_C) ? DEPTH_C : cap_ext);
    assign rear_full = ldq_pkg::CMP_W'(rear_reg) >= (used - ldq_pkg::CMP_W'(1));

    always_comb begin
        front_next       = front_reg;
        rear_next        = rear_reg;
        empty_next       = empty_reg;
        pend_status_next = pend_status_reg;
        pend_read_next   = pend_read_reg;
        wr_en            = 1'b0;
        wr_addr          = front_reg;
        rd_en            = 1'b0;
        rd_addr          = front_reg;
        if (cmd.accept) begin
            pend_status_next = ldq_pkg::STAT_OK;
            pend_read_next   = 1'b0;
            case (mode)
                ldq_pkg::MODE_PUSH_FRONT: begin
                    if (empty_reg) begin
                        pend_status_next = ldq_pkg::STAT_REFUSED;
                    end else if (front_reg == IDX_ZERO) begin
                        pend_status_next = ldq_pkg::STAT_OVERFLOW;
                    end else begin
                        front_next = front_reg - IDX_ONE;
                        wr_en      = 1'b1;
                        wr_addr    = front_reg - IDX_ONE;
                    end
                end
                ldq_pkg::MODE_PUSH_REAR: begin
                    if (empty_reg) begin
                        front_next = IDX_ZERO;
                        rear_next  = IDX_ZERO;
                        empty_next = 1'b0;
                        wr_en      = 1'b1;
                        wr_addr    = IDX_ZERO;
                    end else if (rear_full) begin
                        pend_status_next = ldq_pkg::STAT_OVERFLOW;
                    end else begin
                        rear_next = rear_reg + IDX_ONE;
                        wr_en     = 1'b1;
                        wr_addr   = rear_reg + IDX_ONE;
                    end
                end
                ldq_pkg::MODE_POP_FRONT: begin
                    if (empty_reg) begin
                        pend_status_next = ldq_pkg::STAT_UNDERFLOW;
                    end else begin
                        pend_read_next = 1'b1;
                        rd_en          = 1'b1;
                        rd_addr        = front_reg;
                        if (front_reg == rear_reg) begin
                            front_next = IDX_ZERO;
                            rear_next  = IDX_ZERO;
                            empty_next = 1'b1;
                        end else begin
                            front_next = front_reg + IDX_ONE;
                        end
                    end
                end
                ldq_pkg::MODE_POP_REAR: begin
                    if (empty_reg) begin
                        pend_status_next = ldq_pkg::STAT_UNDERFLOW;
                    end else begin
                        pend_read_next = 1'b1;
                        rd_en          = 1'b1;
                        rd_addr        = rear_reg;
                        if (front_reg == rear_reg) begin
                            front_next = IDX_ZERO;
                            rear_next  = IDX_ZERO;
                            empty_next = 1'b1;
                        end else begin
                            rear_next = rear_reg - IDX_ONE;
                        end
                    end
                end
                default: begin
                    pend_status_next = ldq_pkg::STAT_OK;
                end
            endcase
        end
    end

    ldq_ram #(
        .WIDTH (ldq_pkg::WORD_W),
        .DEPTH (ldq_pkg::DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg       <= IDX_ZERO;
            rear_reg        <= IDX_ZERO;
            empty_reg       <= 1'b1;
            cap_reg         <= ldq_pkg::CAP_RESET;
            pend_status_reg <= ldq_pkg::STAT_OK;
            pend_read_reg   <= 1'b0;
        end else begin
            front_reg       <= front_next;
            rear_reg        <= rear_next;
            empty_reg       <= empty_next;
            pend_status_reg <= pend_status_next;
            pend_read_reg   <= pend_read_next;
            if (cfg_wr) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            value_out_reg <= pend_read_reg ? rd_data : '0;
            status_reg    <= pend_status_reg;
        end
    end

    assign value_out = value_out_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_empty_indices: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg |-> (front_reg == IDX_ZERO && rear_reg == IDX_ZERO))
        else $error("empty deque with nonzero indices");
    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty_reg |-> (front_reg <= rear_reg))
        else $error("front index passed rear index");
    a_read_ok_status: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_read_reg |-> (pend_status_reg == ldq_pkg::STAT_OK))
        else $error("pending read with failure status");
`endif

endmodule

`default_nettype wire

// ----- tb/ldq_checker.sv -----
// Checker for the linear deque engine: tracks the deque contents and compares every result.
`timescale 1ns / 100ps

module ldq_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    // Fields from bit 0: mode[1:0], value[33:2], zero padding.
    input  wire logic [ldq_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // Fields from bit 0: value_out[31:0], status[33:32], zero padding.
    input  wire logic [ldq_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [ldq_pkg::CAP_W-1:0]       cfg_data,
    output int                                   fail_count,
    output int                                   results_owed
);

    typedef struct packed {
        logic [ldq_pkg::WORD_W-1:0] word;
        logic [ldq_pkg::STAT_W-1:0] stat;
    } deque_result_t;

    logic [ldq_pkg::WORD_W-1:0] entry_copy [ldq_pkg::DEPTH];
    logic [ldq_pkg::IDX_W-1:0]  front_q;
    logic [ldq_pkg::IDX_W-1:0]  rear_q;
    logic                       empty_q;
    logic [ldq_pkg::CAP_W-1:0]  cap_q;
    deque_result_t              awaited_results [$];

    initial begin
        fail_count = 0;
        results_owed = 0;
    end

    function automatic deque_result_t apply_deque_op(
            input logic [ldq_pkg::MODE_W-1:0] op,
            input logic [ldq_pkg::WORD_W-1:0] word);
        deque_result_t r;
        int limit;
        r.word = '0;
        r.stat = ldq_pkg::STAT_OK;
        limit = (cap_q == 0) ? 1 :
                ((cap_q > ldq_pkg::DEPTH) ? ldq_pkg::DEPTH : int'(cap_q));
        case (op)
            ldq_pkg::MODE_PUSH_FRONT: begin
                if (empty_q) begin
                    r.stat = ldq_pkg::STAT_REFUSED;
                end else if (front_q == 0) begin
                    r.stat = ldq_pkg::STAT_OVERFLOW;
                end else begin
                    front_q = front_q - 1'b1;
                    entry_copy[front_q] = word;
                end
            end
            ldq_pkg::MODE_PUSH_REAR: begin
                if (empty_q) begin
                    front_q = '0;
                    rear_q = '0;
                    empty_q = 1'b0;
                    entry_copy[0] = word;
                end else if (int'(rear_q) >= limit - 1) begin
                    r.stat = ldq_pkg::STAT_OVERFLOW;
                end else begin
                    rear_q = rear_q + 1'b1;
                    entry_copy[rear_q] = word;
                end
            end
            ldq_pkg::MODE_POP_FRONT: begin
                if (empty_q) begin
                    r.stat = ldq_pkg::STAT_UNDERFLOW;
                end else begin
                    r.word = entry_copy[front_q];
                    if (front_q == rear_q) begin
                        front_q = '0;
                        rear_q = '0;
                        empty_q = 1'b1;
                    end else begin
                        front_q = front_q + 1'b1;
                    end
                end
            end
            default: begin
                if (empty_q) begin
                    r.stat = ldq_pkg::STAT_UNDERFLOW;
                end else begin
                    r.word = entry_copy[rear_q];
                    if (front_q == rear_q) begin
                        front_q = '0;
                        rear_q = '0;
                        empty_q = 1'b1;
                    end else begin
                        rear_q = rear_q - 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [ldq_pkg::WORD_W-1:0] got,
                                   input logic [ldq_pkg::WORD_W-1:0] want);
        $display("ldq_checker: %s mismatch, got %h, expected %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        deque_result_t want;
        deque_result_t got;
        if (!aresetn) begin
            awaited_results.delete();
            front_q = '0;
            rear_q = '0;
            empty_q = 1'b1;
            cap_q = ldq_pkg::CAP_RESET;
            results_owed <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_q = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                got.word = m_tdata[ldq_pkg::WORD_W-1:0];
                got.stat = m_tdata[ldq_pkg::WORD_W +: ldq_pkg::STAT_W];
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected transaction", got.word, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.word !== want.word) begin
                        report_mismatch("value_out", got.word, want.word);
                    end
                    if (got.stat !== want.stat) begin
                        report_mismatch("status", ldq_pkg::WORD_W'(got.stat),
                                        ldq_pkg::WORD_W'(want.stat));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(apply_deque_op(
                    s_tdata[ldq_pkg::MODE_W-1:0],
                    s_tdata[ldq_pkg::MODE_W +: ldq_pkg::WORD_W]));
            end
            results_owed <= awaited_results.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the linear deque engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ldq_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ldq_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [ldq_pkg::CAP_W-1:0]       cfg_data;
    int                              fail_count;
    int                              results_owed;
    int                              cycles;
    bit                              steady;

    linear_deque_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ldq_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial begin
        aclk = 1'b0;
    end

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // Receiver: a random stall before every result, none during steady stretches.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_op(input logic [ldq_pkg::MODE_W-1:0] op,
                           input logic [ldq_pkg::WORD_W-1:0] word);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(ldq_pkg::IN_TDATA_W-ldq_pkg::MODE_W-ldq_pkg::WORD_W){1'b0}},
                    word, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [ldq_pkg::CAP_W-1:0] cap);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ldq_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Bias 0 grows the deque, 1 drains it, 2 is even, 3 fills it hard at the rear.
    function automatic logic [ldq_pkg::MODE_W-1:0] pick_mode(input int bias);
        int r;
        r = $urandom_range(0, 99);
        case (bias)
            0: begin
                if (r < 15) return ldq_pkg::MODE_PUSH_FRONT;
                if (r < 65) return ldq_pkg::MODE_PUSH_REAR;
                if (r < 85) return ldq_pkg::MODE_POP_FRONT;
                return ldq_pkg::MODE_POP_REAR;
            end
            1: begin
                if (r < 10) return ldq_pkg::MODE_PUSH_FRONT;
                if (r < 30) return ldq_pkg::MODE_PUSH_REAR;
                if (r < 65) return ldq_pkg::MODE_POP_FRONT;
                return ldq_pkg::MODE_POP_REAR;
            end
            3: begin
                if (r < 5) return ldq_pkg::MODE_PUSH_FRONT;
                if (r < 90) return ldq_pkg::MODE_PUSH_REAR;
                return ldq_pkg::MODE_POP_FRONT;
            end
            default: return ldq_pkg::MODE_W'(r % 4);
        endcase
    endfunction

    initial begin
        int caps [11] = '{1, 0, 2, 3, 255, 5, 128, 7, 64, 17, 200};
        int biases [11] = '{2, 0, 0, 2, 3, 1, 1, 0, 0, 2, 1};
        int counts [11] = '{40, 40, 50, 50, 160, 60, 120, 60, 80, 60, 60};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        steady = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty deque: both pops underflow and a front push is refused.
        send_op(ldq_pkg::MODE_POP_FRONT, 32'h1234_5678);
        send_op(ldq_pkg::MODE_POP_REAR, 32'hFFFF_FFFF);
        send_op(ldq_pkg::MODE_PUSH_FRONT, 32'hDEAD_BEEF);
        // First rear push lands in entry 0; a front push then overflows.
        send_op(ldq_pkg::MODE_PUSH_REAR, 32'h7FFF_FFFF);
        send_op(ldq_pkg::MODE_PUSH_FRONT, 32'h0000_0001);
        send_op(ldq_pkg::MODE_PUSH_REAR, 32'h8000_0000);
        send_op(ldq_pkg::MODE_PUSH_REAR, 32'hFFFF_FFFF);
        send_op(ldq_pkg::MODE_POP_FRONT, 32'h0000_0000);
        send_op(ldq_pkg::MODE_PUSH_FRONT, 32'h0000_0000);
        send_op(ldq_pkg::MODE_POP_REAR, 32'h0000_0000);
        send_op(ldq_pkg::MODE_POP_REAR, 32'h0000_0000);
        send_op(ldq_pkg::MODE_POP_FRONT, 32'h0000_0000);
        send_op(ldq_pkg::MODE_POP_REAR, 32'h0000_0000);

        // With a single entry the second rear push overflows.
        write_capacity(8'd1);
        send_op(ldq_pkg::MODE_PUSH_REAR, 32'hA5A5_5A5A);
        send_op(ldq_pkg::MODE_PUSH_REAR, 32'h5A5A_A5A5);
        send_op(ldq_pkg::MODE_POP_REAR, 32'h0000_0000);

        // Each phase waits for all results before the capacity changes, but the deque is
        // not drained, so it may hold more elements than the new capacity allows.
        for (int p = 0; p < 11; p++) begin
            write_capacity(ldq_pkg::CAP_W'(caps[p]));
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < counts[p]; i++) begin
                send_op(pick_mode(biases[p]), pick_word());
            end
        end
        steady = 1'b0;

        wait_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && results_owed == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
